// ----- sv/npm_pkg.sv -----
// npm_pkg: shared types and constants for the noisy pixel masker
// used by npm_mask_unit and noisy_pixel_masker; depends on nothing
package npm_pkg;

	// default geometry and counter size
	localparam int SIDE_DEF       = 256;
	localparam int COUNT_BITS_DEF = 16;

	// fixed field widths
	localparam int FACTOR_W = 8;
	localparam int TOTAL_W  = 32;
	localparam int COORD_W  = 8;
	localparam int HIT_W    = 16;

	localparam logic [FACTOR_W-1:0] NOISE_FACTOR_RST = 8'd10;

	// item kinds
	localparam logic KIND_HIT   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// register word index on the config port
	localparam logic REG_NOISE_FACTOR = 1'b0;
	localparam int   PADDR_W          = 3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_PROD
	} state_t;

endpackage

// ----- sv/npm_count_ram.sv -----
// npm_count_ram: single-port-write, single-port-read counter memory
// read data is registered; no dependencies
module npm_count_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/npm_mask_unit.sv -----
// npm_mask_unit: registered products, then a combinational compare for the noisy flag
// tests count * pixels > factor * total; depends on npm_pkg
module npm_mask_unit #(
	parameter int COUNT_BITS = 16,
	parameter int PIXELS     = 65536
) (
	input  logic                          clk,
	input  logic                          start,
	input  logic [COUNT_BITS-1:0]         count,
	input  logic [npm_pkg::FACTOR_W-1:0]  factor,
	input  logic [npm_pkg::TOTAL_W-1:0]   total,
	output logic                          masked
);

	localparam int PW = $clog2(PIXELS + 1);
	localparam int LW = COUNT_BITS + PW;
	localparam int RW = npm_pkg::FACTOR_W + npm_pkg::TOTAL_W;
	localparam int CW = (LW > RW) ? LW : RW;

	logic [LW-1:0] lhs_s1;
	logic [RW-1:0] rhs_s1;

	// one multiplier each side, registered
	always_ff @(posedge clk) begin
		if (start) begin
			lhs_s1 <= LW'(count) * LW'(PIXELS);
			rhs_s1 <= RW'(factor) * RW'(total);
		end
	end

	assign masked = CW'(lhs_s1) > CW'(rhs_s1);

endmodule

// ----- sv/noisy_pixel_masker.sv -----
// noisy_pixel_masker: per-pixel hit histogram with noisy-pixel flag
// depends on npm_pkg, npm_count_ram, npm_mask_unit
//
// channel | direction | handshake           | word
// --------+-----------+---------------------+------------------------------------
// in      | in        | in_valid / in_stall | kind, column, row
// out     | out       | out_valid/out_stall | pixel_column, pixel_row, hit_count,
//         |           |                     | masked
// config  | in        | apb psel/penable    | noise_factor at byte address 0
//
// a hit word goes through a memory read, then write-back of the count
// a query word goes through a memory read, the product registers, then the compare
// the block takes no new word until the previous one is through
// after reset a clearing pass writes zero to all SIDE*SIDE counters, one per cycle;
// in_stall is high throughout, config writes still taken
// a query result waits in the output register while out_stall is high; the next
// word is taken only once that register can be loaded
module noisy_pixel_masker #(
	parameter int SIDE       = npm_pkg::SIDE_DEF,
	parameter int COUNT_BITS = npm_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [npm_pkg::COORD_W-1:0]   column,
	input  logic [npm_pkg::COORD_W-1:0]   row,
	// result words
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [npm_pkg::COORD_W-1:0]   pixel_column,
	output logic [npm_pkg::COORD_W-1:0]   pixel_row,
	output logic [npm_pkg::HIT_W-1:0]     hit_count,
	output logic                          masked,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int PIXELS = SIDE * SIDE;
	localparam int AW     = $clog2(PIXELS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	npm_pkg::state_t state_q, state_d;

	// config register
	logic [npm_pkg::FACTOR_W-1:0] factor_q;
	logic                         cfg_wr;

	// accept and address decode
	logic          accept;
	logic          on_sensor;
	logic [AW-1:0] addr;

	// first stage: word held while the memory read completes
	logic                         kind_s1;
	logic                         on_s1;
	logic [AW-1:0]                addr_s1;
	logic [npm_pkg::COORD_W-1:0]  column_s1;
	logic [npm_pkg::COORD_W-1:0]  row_s1;

	// second stage: query waiting on the compare
	logic [npm_pkg::COORD_W-1:0]  column_s2;
	logic [npm_pkg::COORD_W-1:0]  row_s2;
	logic [npm_pkg::HIT_W-1:0]    hit_s2;

	logic [npm_pkg::TOTAL_W-1:0]  total_q;
	logic [AW-1:0]                clear_idx_q;

	// memory signals
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	// read data gated by on-sensor, plus its saturated forms
	logic [COUNT_BITS-1:0] count;
	logic [COUNT_BITS-1:0] count_inc;
	logic [31:0]           count_wide;
	logic [npm_pkg::HIT_W-1:0] count_hit;

	logic mask_start;
	logic mask_res;

	// output register control
	logic out_load;
	logic out_valid_q;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[npm_pkg::PADDR_W-1] == npm_pkg::REG_NOISE_FACTOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= npm_pkg::NOISE_FACTOR_RST;
		end else if (cfg_wr) begin
			factor_q <= pwdata[npm_pkg::FACTOR_W-1:0];
		end
	end

	assign prdata = (paddr[npm_pkg::PADDR_W-1] == npm_pkg::REG_NOISE_FACTOR)
		? 32'(factor_q) : 32'd0;

	// ---------------------------------------------------------------- decode
	// pixel (column, row) lives at entry column * SIDE + row
	assign on_sensor = (32'(column) < 32'(SIDE)) && (32'(row) < 32'(SIDE));
	assign addr      = AW'(column) * AW'(SIDE) + AW'(row);
	assign accept    = in_valid && !in_stall;

	// ---------------------------------------------------------------- counts
	assign count      = on_s1 ? ram_rdata : '0;
	assign count_inc  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
	assign count_wide = 32'(count);
	// wide counters report at most the 16-bit ceiling
	assign count_hit  = (|count_wide[31:npm_pkg::HIT_W]) ? '1 : count_wide[npm_pkg::HIT_W-1:0];

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = addr_s1;
		ram_wdata  = count_inc;
		mask_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			npm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clear_idx_q;
				ram_wdata = '0;
				if (clear_idx_q == AW'(PIXELS - 1)) begin
					state_d = npm_pkg::ST_IDLE;
				end
			end
			npm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = npm_pkg::ST_LOOK;
				end
			end
			npm_pkg::ST_LOOK: begin
				if (kind_s1 == npm_pkg::KIND_HIT) begin
					// write back the incremented count
					ram_we  = on_s1;
					state_d = npm_pkg::ST_IDLE;
				end else begin
					mask_start = 1'b1;
					state_d    = npm_pkg::ST_PROD;
				end
			end
			npm_pkg::ST_PROD: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = npm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = npm_pkg::ST_IDLE;
			end
		endcase
	end

	// clearing pass index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_idx_q <= '0;
		end else if (state_q == npm_pkg::ST_CLEAR) begin
			clear_idx_q <= clear_idx_q + AW'(1);
		end
	end

	// running total, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (state_q == npm_pkg::ST_LOOK && kind_s1 == npm_pkg::KIND_HIT
				&& on_s1 && total_q != '1) begin
			total_q <= total_q + npm_pkg::TOTAL_W'(1);
		end
	end

	// ---------------------------------------------------------------- pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			on_s1     <= on_sensor;
			addr_s1   <= addr;
			column_s1 <= column;
			row_s1    <= row;
		end
	end

	always_ff @(posedge clk) begin
		if (mask_start) begin
			column_s2 <= column_s1;
			row_s2    <= row_s1;
			hit_s2    <= count_hit;
		end
	end

	// ---------------------------------------------------------------- memory
	npm_count_ram #(
		.DEPTH (PIXELS),
		.AW    (AW),
		.DW    (COUNT_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (addr),
		.rd_data (ram_rdata)
	);

	// ---------------------------------------------------------------- mask test
	// off-sensor queries carry a zero count, so the flag is clear for them
	npm_mask_unit #(
		.COUNT_BITS (COUNT_BITS),
		.PIXELS     (PIXELS)
	) u_mask (
		.clk    (clk),
		.start  (mask_start),
		.count  (count),
		.factor (factor_q),
		.total  (total_q),
		.masked (mask_res)
	);

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_column <= column_s2;
			pixel_row    <= row_s2;
			hit_count    <= hit_s2;
			masked       <= mask_res;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------- checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == npm_pkg::ST_LOOK)
		else $error("accepted word did not move to the lookup cycle");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == npm_pkg::ST_CLEAR
			|| (state_q == npm_pkg::ST_LOOK && kind_s1 == npm_pkg::KIND_HIT && on_s1)))
		else $error("counter memory written outside clearing or hit write-back");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> total_q >= $past(total_q))
		else $error("running total went down");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (kind_s1 == npm_pkg::KIND_QUERY))
		else $error("result produced for a hit word");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npm_pkg::ST_LOOK || state_q == npm_pkg::ST_PROD) |-> !accept)
		else $error("word accepted while one is in flight");

endmodule

// ----- tb/sv/noisy_pixel_masker_test.sv -----
// noisy_pixel_masker_test: self-checking bench for the noisy pixel masker, with a histogram
// predictor, a queue-fed word driver, a result monitor, and apb writes of the noise factor
// depends on npm_pkg and noisy_pixel_masker
`timescale 1ns / 100ps

module noisy_pixel_masker_test;

	localparam int SENSOR_SIDE  = npm_pkg::SIDE_DEF;
	localparam int PIXEL_TOTAL  = SENSOR_SIDE * SENSOR_SIDE;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int SETTLE       = 8;     // drain margin for the last hit's write-back, hits give no result word
	localparam int SEGMENT_SIZE = 100;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		logic                        kind;
		logic [npm_pkg::COORD_W-1:0] column;
		logic [npm_pkg::COORD_W-1:0] row;
	} sensor_word_t;

	typedef struct packed {
		logic [npm_pkg::COORD_W-1:0] column;
		logic [npm_pkg::COORD_W-1:0] row;
		logic [npm_pkg::HIT_W-1:0]   count;
		logic                        masked;
	} pixel_report_t;

	// clock, reset and block inputs, all known from time zero
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        kind      = npm_pkg::KIND_HIT;
	logic [npm_pkg::COORD_W-1:0] column    = '0;
	logic [npm_pkg::COORD_W-1:0] row       = '0;
	logic                        out_stall = 1'b0;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [npm_pkg::PADDR_W-1:0] paddr     = '0;
	logic [31:0]                 pwdata    = '0;

	logic                        in_stall;
	logic                        out_valid;
	logic [npm_pkg::COORD_W-1:0] pixel_column;
	logic [npm_pkg::COORD_W-1:0] pixel_row;
	logic [npm_pkg::HIT_W-1:0]   hit_count;
	logic                        masked;
	logic [31:0]                 prdata;
	logic                        pready;

	noisy_pixel_masker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.column      (column),
		.row         (row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_column(pixel_column),
		.pixel_row   (pixel_row),
		.hit_count   (hit_count),
		.masked      (masked),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: one saturating counter per pixel, the running total and the factor
	logic [npm_pkg::HIT_W-1:0]    pixel_hits [PIXEL_TOTAL];
	logic [npm_pkg::TOTAL_W-1:0]  hit_total  = '0;
	logic [npm_pkg::FACTOR_W-1:0] factor_now = npm_pkg::NOISE_FACTOR_RST;

	sensor_word_t  pending_words [$];
	pixel_report_t expected_reports [$];

	int unsigned words_queued = 0;
	int unsigned words_taken  = 0;
	int unsigned reports_seen = 0;
	int unsigned masked_seen  = 0;
	int unsigned full_seen    = 0;
	int unsigned errors       = 0;
	int unsigned cycle_count  = 0;
	bit          idle_on      = 1'b1;
	int unsigned send_gap     = 0;
	int unsigned stall_left   = 0;
	sensor_word_t next_word;

	// hot pixels get most of the random hits so that some counts stand well above the mean
	logic [npm_pkg::COORD_W-1:0] hot_column [6];
	logic [npm_pkg::COORD_W-1:0] hot_row    [6];
	logic [npm_pkg::COORD_W-1:0] last_column = '0;
	logic [npm_pkg::COORD_W-1:0] last_row    = '0;

	initial begin
		foreach (pixel_hits[i])
			pixel_hits[i] = '0;
	end

	// ------------------------------------------------------------------
	// predictor: applies one accepted word to the histogram, and for a
	// query works out the result word the block owes
	// ------------------------------------------------------------------
	task automatic tally_word(input logic k, input logic [npm_pkg::COORD_W-1:0] c,
			input logic [npm_pkg::COORD_W-1:0] r);
		int unsigned   index;
		pixel_report_t due;
		logic [63:0]   scaled_count;
		logic [63:0]   factor_total;
		index = c * SENSOR_SIDE + r;
		if (k == npm_pkg::KIND_HIT) begin
			// both counters stick at their top value
			if (pixel_hits[index] != '1)
				pixel_hits[index] = pixel_hits[index] + 1'b1;
			if (hit_total != '1)
				hit_total = hit_total + 1'b1;
		end else begin
			// mean test without a divide: count * pixels > factor * total
			scaled_count = 64'(pixel_hits[index]) * 64'(PIXEL_TOTAL);
			factor_total = 64'(factor_now) * 64'(hit_total);
			due.column = c;
			due.row    = r;
			due.count  = pixel_hits[index];
			due.masked = scaled_count > factor_total;
			expected_reports.push_back(due);
		end
	endtask

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// driver: holds a word until it is taken, then either loads the next
	// pending word or opens an idle gap
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tally_word(kind, column, row);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && idle_on &&
						$urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					kind     <= next_word.kind;
					column   <= next_word.column;
					row      <= next_word.row;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each taken result word against the oldest
	// expectation and throws stall bursts
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pixel_report_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result word with none expected, actual col %0d row %0d",
							$time, pixel_column, pixel_row);
				end else begin
					due = expected_reports.pop_front();
					check_field("pixel_column", due.column, pixel_column);
					check_field("pixel_row", due.row, pixel_row);
					check_field("hit_count", due.count, hit_count);
					check_field("masked", due.masked, masked);
					if (due.masked)
						masked_seen++;
					if (due.count == '1)
						full_seen++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_word(input logic k, input logic [npm_pkg::COORD_W-1:0] c,
			input logic [npm_pkg::COORD_W-1:0] r);
		sensor_word_t w;
		w.kind   = k;
		w.column = c;
		w.row    = r;
		pending_words.push_back(w);
		words_queued++;
		if (k == npm_pkg::KIND_HIT) begin
			last_column = c;
			last_row    = r;
		end
	endtask

	// mostly hits, most of them on the hot pixels and some spread; queries of hot, recent and random pixels
	task automatic queue_random_words(input int unsigned n);
		int unsigned pick;
		int unsigned h;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			h    = $urandom_range(0, 5);
			if (pick < 40)
				queue_word(npm_pkg::KIND_HIT, hot_column[h], hot_row[h]);
			else if (pick < 65)
				queue_word(npm_pkg::KIND_HIT, npm_pkg::COORD_W'($urandom),
					npm_pkg::COORD_W'($urandom));
			else if (pick < 80)
				queue_word(npm_pkg::KIND_QUERY, hot_column[h], hot_row[h]);
			else if (pick < 90)
				queue_word(npm_pkg::KIND_QUERY, last_column, last_row);
			else
				queue_word(npm_pkg::KIND_QUERY, npm_pkg::COORD_W'($urandom),
					npm_pkg::COORD_W'($urandom));
		end
	endtask

	// everything sent and answered, then a settle margin for the last hit's write-back
	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (words_taken != words_queued || expected_reports.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// apb write of the noise factor, then a read back of it
	task automatic set_noise_factor(input logic [npm_pkg::FACTOR_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= npm_pkg::PADDR_W'(int'(npm_pkg::REG_NOISE_FACTOR) * 4);
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		factor_now = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		check_field("noise_factor read back", factor_now, prdata[npm_pkg::FACTOR_W-1:0]);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d of %0d words taken, %0d results owed",
			cycle_count, words_taken, words_queued, expected_reports.size());
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [npm_pkg::FACTOR_W-1:0] factor_plan [8];
		logic [npm_pkg::COORD_W-1:0]  full_column;
		logic [npm_pkg::COORD_W-1:0]  full_row;
		factor_plan = '{8'd255, 8'd0, 8'd37, 8'd1, 8'd200, 8'd128, 8'd10, 8'd255};
		factor_plan[5] = npm_pkg::FACTOR_W'($urandom_range(2, 254));
		foreach (hot_column[i]) begin
			hot_column[i] = npm_pkg::COORD_W'($urandom);
			hot_row[i]    = npm_pkg::COORD_W'($urandom);
		end
		full_column = npm_pkg::COORD_W'($urandom);
		full_row    = npm_pkg::COORD_W'($urandom);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// the register can be written while the block is still clearing its counters
		set_noise_factor(8'd1);

		// directed: corner pixels, a pixel hit several times, a pixel never hit
		queue_word(npm_pkg::KIND_HIT, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_HIT, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_HIT, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_HIT, 8'd255, 8'd255);
		queue_word(npm_pkg::KIND_HIT, 8'd0, 8'd255);
		queue_word(npm_pkg::KIND_HIT, 8'd255, 8'd0);
		queue_word(npm_pkg::KIND_HIT, 8'd170, 8'd85);
		queue_word(npm_pkg::KIND_HIT, 8'd85, 8'd170);
		queue_word(npm_pkg::KIND_QUERY, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_QUERY, 8'd255, 8'd255);
		queue_word(npm_pkg::KIND_QUERY, 8'd0, 8'd255);
		queue_word(npm_pkg::KIND_QUERY, 8'd255, 8'd0);
		queue_word(npm_pkg::KIND_QUERY, 8'd170, 8'd85);
		queue_word(npm_pkg::KIND_QUERY, 8'd85, 8'd170);
		queue_word(npm_pkg::KIND_QUERY, 8'd200, 8'd13);
		queue_word(npm_pkg::KIND_HIT, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_QUERY, 8'd0, 8'd0);
		wait_for_drain();

		// a zero factor flags any pixel with a hit, but never an empty one
		set_noise_factor(8'd0);
		queue_word(npm_pkg::KIND_QUERY, 8'd0, 8'd0);
		queue_word(npm_pkg::KIND_QUERY, 8'd200, 8'd13);
		queue_word(npm_pkg::KIND_QUERY, 8'd85, 8'd170);

		for (int seg = 0; seg < 8; seg++) begin
			wait_for_drain();
			set_noise_factor(factor_plan[seg]);
			// the final segment runs with no idling on either side
			idle_on = (seg != 7) && ($urandom_range(0, 3) != 0);
			queue_random_words(SEGMENT_SIZE);
			if (seg == 4 || seg == 6)
				queue_word(npm_pkg::KIND_QUERY, full_column, full_row);
		end
		wait_for_drain();

		$display("sent %0d words, checked %0d result words (%0d flagged noisy, %0d saturated)",
			words_taken, reports_seen, masked_seen, full_seen);
		$display("hit total reached %0d, noise factor swept over 0, 1, 255 and others",
			hit_total);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
